// ===== rtl/core/utt_pkg.sv =====
// Package for the tick-driven serial transmitter: request and result structs,
// internal state and settings structs, register indexes and frame constants.
// No dependencies; used by utt_step and uart_tick_transmitter_unit.
`timescale 1ns / 1ps

package utt_pkg;

  // Frame layout
  localparam int unsigned DataBits  = 8;
  localparam int unsigned StopSlot  = 9;
  localparam int unsigned CntWidth  = 14;
  localparam int unsigned PtWidth   = 12;   // holds 255 * 9
  localparam int unsigned BtWidth   = 8;
  localparam int unsigned FsWidth   = 6;

  // Register reset values
  localparam logic [BtWidth-1:0]  BitTicksReset   = 8'd8;
  localparam logic [FsWidth-1:0]  FrameSlotsReset = 6'd30;
  localparam logic [CntWidth-1:0] SlotEndReset    = 14'd240;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgBitTicks   = 1'b0,
    CfgFrameSlots = 1'b1
  } cfg_idx_e;

  // One input request
  typedef struct packed {
    logic [7:0] char_in;
    logic       start_req;
  } utt_in_t;

  // One result
  typedef struct packed {
    logic tx_line;
    logic advance;
    logic restart;
    logic busy_res;
  } utt_out_t;

  // Transmitter state carried from tick to tick
  typedef struct packed {
    logic                active;
    logic [CntWidth-1:0] tick_count;
    logic                line_level;
  } utt_state_t;

  // Settings seen by the step logic
  typedef struct packed {
    logic [BtWidth-1:0]  bit_ticks;
    logic [CntWidth-1:0] slot_end;
  } utt_cfg_t;

endpackage

// ===== rtl/core/utt_step.sv =====
// Next-state and result logic for one tick of the serial transmitter.
// Depends on utt_pkg for the state, settings, request and result structs.
`timescale 1ns / 1ps

module utt_step (
  input  utt_pkg::utt_state_t st_i,
  input  utt_pkg::utt_cfg_t   cfg_i,
  input  utt_pkg::utt_in_t    req_i,
  output utt_pkg::utt_state_t st_o,
  output utt_pkg::utt_out_t   res_o
);

  logic [utt_pkg::PtWidth-1:0] data_pt [utt_pkg::DataBits];
  logic [utt_pkg::PtWidth-1:0] stop_pt;

  // Build the bit boundaries from the tick period
  always_comb begin
    for (int k = 0; k < utt_pkg::DataBits; k++) begin
      data_pt[k] = utt_pkg::PtWidth'(cfg_i.bit_ticks) * utt_pkg::PtWidth'(k + 1);
    end
    stop_pt = utt_pkg::PtWidth'(cfg_i.bit_ticks) * utt_pkg::PtWidth'(utt_pkg::StopSlot);
  end

  // Apply start and end of message, then walk the slot counter
  always_comb begin
    logic                          matched;
    logic [utt_pkg::CntWidth-1:0]  cnt;
    st_o    = st_i;
    res_o   = '0;
    matched = 1'b0;
    cnt     = st_i.tick_count;

    st_o.active   = (st_i.active | req_i.start_req) & (req_i.char_in != '0);
    res_o.restart = (req_i.char_in == '0);

    if (st_o.active) begin
      if (cnt == '0) begin
        st_o.line_level = 1'b0;
        matched         = 1'b1;
      end
      for (int k = 0; k < utt_pkg::DataBits; k++) begin
        if (!matched && cnt == utt_pkg::CntWidth'(data_pt[k])) begin
          st_o.line_level = req_i.char_in[k];
          matched         = 1'b1;
        end
      end
      if (!matched && cnt == utt_pkg::CntWidth'(stop_pt)) begin
        st_o.line_level = 1'b1;
        matched         = 1'b1;
      end
      if (!matched && cnt == cfg_i.slot_end) begin
        st_o.tick_count = '0;
        res_o.advance   = 1'b1;
      end else begin
        st_o.tick_count = cnt + 1'b1;
      end
    end

    res_o.tx_line  = st_o.line_level;
    res_o.busy_res = st_o.active;
  end

endmodule

// ===== rtl/core/uart_tick_transmitter_unit.sv =====
// Tick-driven 8N1 serial transmitter with a slotted character frame. Each
// request is one tick and yields exactly one result; a request is taken every
// clock cycle while the skid stage is empty, and its result is registered. The whole
// tick is one pass through the step logic into the result register, and a
// one-entry skid stage behind that register lets the next request in while a
// result still waits, so ready depends only on the skid stage being empty.
// The settings registers are written through a plain write port; the slot
// length product is formed at the write. Depends on utt_pkg and utt_step.
`timescale 1ns / 1ps

module uart_tick_transmitter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  utt_pkg::utt_in_t            in_req_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output utt_pkg::utt_out_t           out_res_o,
  // Settings write port
  input  logic                        cfg_we_i,
  input  utt_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [utt_pkg::BtWidth-1:0] cfg_wdata_i
);

  logic [utt_pkg::BtWidth-1:0]  bit_ticks_q;
  logic [utt_pkg::FsWidth-1:0]  frame_slots_q;
  logic [utt_pkg::CntWidth-1:0] slot_end_q;

  utt_pkg::utt_state_t state_q, state_d;
  utt_pkg::utt_cfg_t   cfg;
  utt_pkg::utt_out_t   res;

  utt_pkg::utt_out_t   out_q, skid_q;
  logic                out_valid_q, skid_valid_q;

  logic in_fire, out_take;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_take = out_valid_q & out_ready_i;

  // Hold the settings and the slot length product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q   <= utt_pkg::BitTicksReset;
      frame_slots_q <= utt_pkg::FrameSlotsReset;
      slot_end_q    <= utt_pkg::SlotEndReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        utt_pkg::CfgBitTicks: begin
          bit_ticks_q <= cfg_wdata_i;
          slot_end_q  <= utt_pkg::CntWidth'(cfg_wdata_i) *
                         utt_pkg::CntWidth'(frame_slots_q);
        end
        utt_pkg::CfgFrameSlots: begin
          frame_slots_q <= cfg_wdata_i[utt_pkg::FsWidth-1:0];
          slot_end_q    <= utt_pkg::CntWidth'(bit_ticks_q) *
                           utt_pkg::CntWidth'(cfg_wdata_i[utt_pkg::FsWidth-1:0]);
        end
        default: ;
      endcase
    end
  end

  assign cfg.bit_ticks = bit_ticks_q;
  assign cfg.slot_end  = slot_end_q;

  utt_step u_step (
    .st_i  (state_q),
    .cfg_i (cfg),
    .req_i (in_req_i),
    .st_o  (state_d),
    .res_o (res)
  );

  // Advance the transmitter state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.active     <= 1'b0;
      state_q.tick_count <= '0;
      state_q.line_level <= 1'b1;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result register with a one-entry skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // The skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the result register is empty");

  // A zero byte always ends the message
  a_zero_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i.char_in == '0) |=> !state_q.active)
    else $error("transmitter still active after a zero byte");

  // The end of a slot clears the tick counter
  a_adv_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.advance) |=> (state_q.tick_count == '0))
    else $error("tick counter not cleared at slot end");

  // State moves only on an accepted tick
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("transmitter state changed without a request");

  // The line level reported matches the state left behind
  a_line_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q.line_level == $past(res.tx_line)))
    else $error("reported line level differs from held level");

endmodule

// ===== tb/sv/utt_line_checker.sv =====
// Checker for the tick-driven serial transmitter: watches the request, result
// and settings ports, predicts each result and compares it field by field.
// Depends on utt_pkg; instantiated beside the block by tb_uart_tick_transmitter_unit.
`timescale 1ns / 1ps

module utt_line_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  utt_pkg::utt_in_t            in_req_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  utt_pkg::utt_out_t           out_res_i,
  input  logic                        cfg_we_i,
  input  utt_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [utt_pkg::BtWidth-1:0] cfg_wdata_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o,
  output int unsigned                 checked_o,
  output int unsigned                 slot_ends_o,
  output int unsigned                 msg_ends_o
);

  // Own copy of the transmitter state and its settings
  utt_pkg::utt_state_t         line_st;
  logic [utt_pkg::BtWidth-1:0] bit_ticks;
  logic [utt_pkg::FsWidth-1:0] frame_slots;

  // Results owed for accepted requests, oldest first
  utt_pkg::utt_out_t line_due_q[$];
  int unsigned fails     = 0;
  int unsigned checked   = 0;
  int unsigned slot_ends = 0;
  int unsigned msg_ends  = 0;

  assign fail_count_o = fails;
  assign checked_o    = checked;
  assign slot_ends_o  = slot_ends;
  assign msg_ends_o   = msg_ends;

  // Work out the line level and pulses that one tick produces
  task automatic serialise_tick(input utt_pkg::utt_in_t req, output utt_pkg::utt_out_t res);
    int unsigned bt;
    int unsigned cnt;
    int unsigned k;
    logic        hit;
    logic        slot_done;
    logic        msg_done;
    bt        = bit_ticks;
    cnt       = line_st.tick_count;
    hit       = 1'b0;
    slot_done = 1'b0;
    msg_done  = 1'b0;
    // Start strobe first; a zero byte then overrides it
    if (req.start_req) line_st.active = 1'b1;
    if (req.char_in == 8'd0) begin
      line_st.active = 1'b0;
      msg_done       = 1'b1;
    end
    if (line_st.active) begin
      // Earliest matching point wins: start bit, data bits, stop, slot end
      if (cnt == 0) begin
        line_st.line_level = 1'b0;
        hit                = 1'b1;
      end
      for (k = 0; k < utt_pkg::DataBits; k++) begin
        if (!hit && cnt == bt * (k + 1)) begin
          line_st.line_level = req.char_in[k];
          hit                = 1'b1;
        end
      end
      if (!hit && cnt == bt * utt_pkg::StopSlot) begin
        line_st.line_level = 1'b1;
        hit                = 1'b1;
      end
      if (!hit && cnt == bt * frame_slots) begin
        line_st.tick_count = '0;
        slot_done          = 1'b1;
      end else begin
        line_st.tick_count = line_st.tick_count + 1'b1;
      end
    end
    res.tx_line  = line_st.line_level;
    res.advance  = slot_done;
    res.restart  = msg_done;
    res.busy_res = line_st.active;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s mismatch: expected %0b, got %0b", name, want, got);
      fails++;
    end
  endtask

  // Track settings, retire results and predict new requests at each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    utt_pkg::utt_out_t want;
    if (!rst_ni) begin
      line_st     = '{active: 1'b0, tick_count: '0, line_level: 1'b1};
      bit_ticks   = utt_pkg::BitTicksReset;
      frame_slots = utt_pkg::FrameSlotsReset;
      line_due_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == utt_pkg::CfgBitTicks) bit_ticks = cfg_wdata_i;
        else frame_slots = cfg_wdata_i[utt_pkg::FsWidth-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (line_due_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fails++;
        end else begin
          want = line_due_q.pop_front();
          check_field("tx_line", want.tx_line, out_res_i.tx_line);
          check_field("advance", want.advance, out_res_i.advance);
          check_field("restart", want.restart, out_res_i.restart);
          check_field("busy_res", want.busy_res, out_res_i.busy_res);
          checked++;
          if (want.advance) slot_ends++;
          if (want.restart) msg_ends++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        serialise_tick(in_req_i, want);
        line_due_q.push_back(want);
      end
      pending_o <= line_due_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_uart_tick_transmitter_unit.sv =====
// Top of the transmitter testbench: clock, reset, request and result traffic,
// settings writes and the verdict. Depends on utt_pkg, utt_line_checker and
// uart_tick_transmitter_unit.
`timescale 1ns / 1ps

module tb_uart_tick_transmitter_unit;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HiddenTicks  = 30;
  localparam int unsigned HoldCap      = 40;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  utt_pkg::utt_in_t            in_req    = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  utt_pkg::utt_out_t           out_res;
  logic                        cfg_we    = 1'b0;
  utt_pkg::cfg_idx_e           cfg_idx   = utt_pkg::CfgBitTicks;
  logic [utt_pkg::BtWidth-1:0] cfg_wdata = '0;

  int unsigned pending;
  int unsigned fails;
  int unsigned checked;
  int unsigned slot_ends;
  int unsigned msg_ends;
  int unsigned ticks_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned cur_bt        = utt_pkg::BitTicksReset;
  int unsigned cur_fs        = utt_pkg::FrameSlotsReset;
  bit          tx_idle_en    = 1'b1;
  bit          rx_stall_en   = 1'b1;

  always #10 clk = ~clk;

  uart_tick_transmitter_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  utt_line_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_res_i    (out_res),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fails),
    .checked_o    (checked),
    .slot_ends_o  (slot_ends),
    .msg_ends_o   (msg_ends)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Result side: stall at random while stalls are enabled
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_stall_en && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  // Drop the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one tick, optionally after a gap, and hold it until taken
  task automatic send_tick(input logic [7:0] ch, input logic st);
    if (tx_idle_en && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_req   <= '{char_in: ch, start_req: st};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Hold off requests until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both rate registers while the block is idle
  task automatic set_rates(input int unsigned bt, input int unsigned fs);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= utt_pkg::CfgBitTicks;
    cfg_wdata <= bt[utt_pkg::BtWidth-1:0];
    @(posedge clk);
    cfg_idx   <= utt_pkg::CfgFrameSlots;
    cfg_wdata <= utt_pkg::BtWidth'(fs);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_bt = bt;
    cur_fs = fs;
    settings_used++;
  endtask

  // A message: each byte held for roughly one slot, then one or two zero bytes
  task automatic send_message();
    int unsigned nbytes;
    int unsigned hold;
    int unsigned slot;
    int unsigned b;
    int unsigned t;
    logic [7:0]  ch;
    slot   = cur_bt * cur_fs + 1;
    if (slot > HoldCap) slot = HoldCap;
    nbytes = $urandom_range(1, 4);
    for (b = 0; b < nbytes; b++) begin
      ch   = $urandom_range(1, 255);
      hold = slot + $urandom_range(0, 4);
      hold = (hold > 3) ? hold - 2 : 1;
      for (t = 0; t < hold; t++)
        send_tick(ch, (b == 0 && t == 0) || $urandom_range(0, 19) == 0);
    end
    repeat ($urandom_range(1, 2)) send_tick(8'h00, 1'($urandom_range(0, 1)));
  endtask

  // Unstructured ticks: random bytes, frequent zeros, random strobes
  task automatic send_noise();
    logic [7:0] ch;
    repeat ($urandom_range(3, 10)) begin
      ch = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_tick(ch, 1'($urandom_range(0, 1)));
    end
  endtask

  // One rate setting: mostly messages, some noise, idling switched at random
  task automatic run_random(input int unsigned bt, input int unsigned fs,
                            input int unsigned n);
    int unsigned stop_at;
    set_rates(bt, fs);
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_idle_en = !tx_idle_en;
        rx_stall_en <= tx_idle_en;
      end
      if ($urandom_range(0, 29) == 0) drain_results();
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_message();
    end
  endtask

  initial begin
    int unsigned i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset rates: zero byte beats a start strobe, an idle tick, a short start
    send_tick(8'h00, 1'b1);
    send_tick(8'hA5, 1'b0);
    send_tick(8'hA5, 1'b1);
    send_tick(8'hA5, 1'b0);
    send_tick(8'hA5, 1'b0);
    // Counter is held across the message end and resumes on the next start
    send_tick(8'h00, 1'b0);

    // One-tick bit period: walk a full frame to the slot end, then into the next
    set_rates(1, 10);
    send_tick(8'h81, 1'b1);
    for (i = 0; i < 8; i++) send_tick(8'h81, 1'b0);
    for (i = 0; i < 4; i++) send_tick(8'hFF, 1'b0);
    send_tick(8'h00, 1'b1);
    send_tick(8'h7E, 1'b1);
    for (i = 0; i < 3; i++) send_tick(8'h7E, 1'b0);
    send_tick(8'h00, 1'b0);

    // Slot ends grow over the first six phases; the last two phases shrink them again
    run_random(1, 10, 70);
    run_random(2, 12, 50);
    run_random(3, 11, 40);
    run_random(1, 63, 20);
    run_random(4, 20, 20);
    run_random(255, 63, 10);
    run_random(255, 10, 10);
    // Zero bit period: only the start bit can match, the counter runs on
    run_random(0, 10, 20);

    // Slot end hidden behind a data bit: the counter runs past every point
    tx_idle_en = 1'b1;
    rx_stall_en <= 1'b1;
    set_rates(1, 5);
    send_tick(8'($urandom_range(1, 255)), 1'b1);
    repeat (HiddenTicks) send_tick(8'($urandom_range(1, 255)), $urandom_range(0, 3) == 0);

    drain_results();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d ticks under %0d rate settings, ending with a slot end hidden by a data bit.",
             ticks_sent, settings_used);
    $display("Checked %0d results: %0d slot ends, %0d message ends.",
             checked, slot_ends, msg_ends);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
